[src/asgr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_pkg
// Shared types, constants and the CP437 high-half glyph lookup for the
// SGR attribute parser.
// ----------------------------------------------------------------------------
package asgr_pkg;

  localparam int unsigned PairDepth = 64;
  localparam int unsigned PosW      = $clog2(PairDepth);
  localparam int unsigned CountW    = $clog2(PairDepth + 1);
  localparam int unsigned ColW      = 9;
  localparam int unsigned KeyW      = 2 * ColW;

  localparam logic [7:0] ByteEsc   = 8'd27;
  localparam logic [7:0] ByteOpen  = 8'd91;
  localparam logic [7:0] ByteEnd   = 8'd109;
  localparam logic [7:0] ByteSplit = 8'd59;
  localparam logic [7:0] ByteZero  = 8'd48;
  localparam logic [7:0] PairBaseReset = 8'd50;

  typedef enum logic [2:0] {
    PH_PRINT = 3'd0,
    PH_MOD   = 3'd1,
    PH_UNDO  = 3'd2,
    PH_FG    = 3'd3,
    PH_BG    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_OUT
  } state_e;

  // Result of one sweep over the pair cells
  typedef struct packed {
    logic            hit;
    logic [PosW-1:0] pos;
  } lookup_t;

  // CP437 glyph for bytes 128..255
  function automatic logic [15:0] cp437_high(input logic [6:0] idx);
    logic [15:0] g;
    case (idx)
      7'd0: g = 16'h00C7;  7'd1: g = 16'h00FC;  7'd2: g = 16'h00E9;  7'd3: g = 16'h00E2;
      7'd4: g = 16'h00E4;  7'd5: g = 16'h00E0;  7'd6: g = 16'h00E5;  7'd7: g = 16'h00E7;
      7'd8: g = 16'h00EA;  7'd9: g = 16'h00EB;  7'd10: g = 16'h00E8; 7'd11: g = 16'h00EF;
      7'd12: g = 16'h00EE; 7'd13: g = 16'h00EC; 7'd14: g = 16'h00C4; 7'd15: g = 16'h00C5;
      7'd16: g = 16'h00C9; 7'd17: g = 16'h00E6; 7'd18: g = 16'h00C6; 7'd19: g = 16'h00F4;
      7'd20: g = 16'h00F6; 7'd21: g = 16'h00F2; 7'd22: g = 16'h00FB; 7'd23: g = 16'h00F9;
      7'd24: g = 16'h00FF; 7'd25: g = 16'h00D6; 7'd26: g = 16'h00DC; 7'd27: g = 16'h00A2;
      7'd28: g = 16'h00A3; 7'd29: g = 16'h00A5; 7'd30: g = 16'h20A7; 7'd31: g = 16'h0192;
      7'd32: g = 16'h00E1; 7'd33: g = 16'h00ED; 7'd34: g = 16'h00F3; 7'd35: g = 16'h00FA;
      7'd36: g = 16'h00F1; 7'd37: g = 16'h00D1; 7'd38: g = 16'h00AA; 7'd39: g = 16'h00BA;
      7'd40: g = 16'h00BF; 7'd41: g = 16'h2310; 7'd42: g = 16'h00AC; 7'd43: g = 16'h00BD;
      7'd44: g = 16'h00BC; 7'd45: g = 16'h00A1; 7'd46: g = 16'h00AB; 7'd47: g = 16'h00BB;
      7'd48: g = 16'h2591; 7'd49: g = 16'h2592; 7'd50: g = 16'h2593; 7'd51: g = 16'h2502;
      7'd52: g = 16'h2524; 7'd53: g = 16'h2561; 7'd54: g = 16'h2562; 7'd55: g = 16'h2556;
      7'd56: g = 16'h2555; 7'd57: g = 16'h2563; 7'd58: g = 16'h2551; 7'd59: g = 16'h2557;
      7'd60: g = 16'h255D; 7'd61: g = 16'h255C; 7'd62: g = 16'h255B; 7'd63: g = 16'h2510;
      7'd64: g = 16'h2514; 7'd65: g = 16'h2534; 7'd66: g = 16'h252C; 7'd67: g = 16'h251C;
      7'd68: g = 16'h2500; 7'd69: g = 16'h253C; 7'd70: g = 16'h255E; 7'd71: g = 16'h255F;
      7'd72: g = 16'h255A; 7'd73: g = 16'h2554; 7'd74: g = 16'h2569; 7'd75: g = 16'h2566;
      7'd76: g = 16'h2560; 7'd77: g = 16'h2550; 7'd78: g = 16'h256C; 7'd79: g = 16'h2567;
      7'd80: g = 16'h2568; 7'd81: g = 16'h2564; 7'd82: g = 16'h2565; 7'd83: g = 16'h2559;
      7'd84: g = 16'h2558; 7'd85: g = 16'h2552; 7'd86: g = 16'h2553; 7'd87: g = 16'h256B;
      7'd88: g = 16'h256A; 7'd89: g = 16'h2518; 7'd90: g = 16'h250C; 7'd91: g = 16'h2588;
      7'd92: g = 16'h2584; 7'd93: g = 16'h258C; 7'd94: g = 16'h2590; 7'd95: g = 16'h2580;
      7'd96: g = 16'h03B1; 7'd97: g = 16'h00DF; 7'd98: g = 16'h0393; 7'd99: g = 16'h03C0;
      7'd100: g = 16'h03A3; 7'd101: g = 16'h03C3; 7'd102: g = 16'h00B5; 7'd103: g = 16'h03C4;
      7'd104: g = 16'h03A6; 7'd105: g = 16'h0398; 7'd106: g = 16'h03A9; 7'd107: g = 16'h03B4;
      7'd108: g = 16'h221E; 7'd109: g = 16'h03C6; 7'd110: g = 16'h03B5; 7'd111: g = 16'h2229;
      7'd112: g = 16'h2261; 7'd113: g = 16'h00B1; 7'd114: g = 16'h2265; 7'd115: g = 16'h2264;
      7'd116: g = 16'h2320; 7'd117: g = 16'h2321; 7'd118: g = 16'h00F7; 7'd119: g = 16'h2248;
      7'd120: g = 16'h00B0; 7'd121: g = 16'h2219; 7'd122: g = 16'h00B7; 7'd123: g = 16'h221A;
      7'd124: g = 16'h207F; 7'd125: g = 16'h00B2; 7'd126: g = 16'h25A0; 7'd127: g = 16'h00A0;
      default: g = 16'h0000;
    endcase
    return g;
  endfunction

endpackage

[src/asgr_pair_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_pair_cell
// One colour-pair slot: holds a {fore, back} key, takes its neighbour's key
// on a shift and compares its own key against the search key.
// ----------------------------------------------------------------------------
module asgr_pair_cell (
  input  logic                     clk_i,
  input  logic                     shift_i,
  input  logic [asgr_pkg::KeyW-1:0] key_in_i,
  input  logic [asgr_pkg::KeyW-1:0] search_i,
  output logic [asgr_pkg::KeyW-1:0] key_o,
  output logic                     hit_o
);
  import asgr_pkg::*;

  logic [KeyW-1:0] key_q;

  // shift register slot, no reset: only slots below the fill count are used
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q <= key_in_i;
    end
  end

  assign key_o = key_q;
  assign hit_o = (key_q == search_i);

endmodule

[src/asgr_pair_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_pair_chain
// Row of pair cells. A new pair enters at slot 0 and every older pair moves
// one slot along, so slot p holds the pair appended p steps before the newest one.
// ----------------------------------------------------------------------------
module asgr_pair_chain (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [asgr_pkg::KeyW-1:0]   search_i,
  input  logic [asgr_pkg::CountW-1:0] count_i,
  output asgr_pkg::lookup_t          lookup_o
);
  import asgr_pkg::*;

  logic [KeyW-1:0]      link [PairDepth+1];
  logic [PairDepth-1:0] hit;

  assign link[0] = search_i;

  for (genvar p = 0; p < PairDepth; p++) begin : g_cell
    asgr_pair_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift_i),
      .key_in_i (link[p]),
      .search_i (search_i),
      .key_o    (link[p+1]),
      .hit_o    (hit[p])
    );
  end

  // keys are unique, so at most one live slot matches
  always_comb begin
    lookup_o = '0;
    for (int p = 0; p < PairDepth; p++) begin
      if (hit[p] && (CountW'(p) < count_i)) begin
        lookup_o.hit = 1'b1;
        lookup_o.pos = lookup_o.pos | PosW'(p);
      end
    end
  end

endmodule

[src/ansi_sgr_attribute_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_parser
// Byte-wide SGR escape parser with sticky attributes and a colour-pair table.
// ----------------------------------------------------------------------------
// One byte is taken at a time; its result word is offered in the cycle after it is
// taken, or after the ST_SEARCH state when the byte closes a colour or reset code,
// since the colour-pair table (a row of 64 shift cells, compared in parallel) is
// searched and appended in that state of its own. The next byte is accepted once
// the result word has been taken, so no new byte enters while a word is pending,
// and any output stall holds the input too.
// No clearing pass follows reset.
module ansi_sgr_attribute_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        printed_o,
  output logic [15:0] code_point_o,
  output logic [7:0]  attr_mask_o,
  output logic [8:0]  pair_id_o,
  output logic        table_full_o
);
  import asgr_pkg::*;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        base_q;
  logic [7:0]        last_q, last_d;
  logic [ColW-1:0]   fore_q, fore_d, back_q, back_d;
  logic [7:0]        attr_q, attr_d;
  logic [8:0]        pair_q, pair_d;
  logic [CountW-1:0] count_q, count_d;
  logic              printed_q, printed_d, full_q, full_d;
  logic [15:0]       cp_q, cp_d;
  logic              need_lookup;
  logic              in_acc, shift;
  lookup_t           lookup;
  logic [7:0]        c;

  assign in_acc = in_valid_i && in_ready_o;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= PairBaseReset;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // byte parse
  always_comb begin
    c           = in_byte_i;
    phase_d     = phase_q;
    attr_d      = attr_q;
    fore_d      = fore_q;
    back_d      = back_q;
    need_lookup = 1'b0;
    printed_d   = 1'b0;
    cp_d        = '0;
    if (phase_q == PH_MOD || phase_q == PH_UNDO || phase_q == PH_FG || phase_q == PH_BG) begin
      if (in_byte_i == ByteEnd || in_byte_i == ByteSplit) begin
        case (phase_q)
          PH_MOD: begin
            case (last_q)
              8'd48: begin
                attr_d      = '0;
                fore_d      = '1;
                back_d      = '1;
                need_lookup = 1'b1;
              end
              8'd49: attr_d = attr_q | 8'h01;
              8'd50: attr_d = attr_q | 8'h02;
              8'd51: attr_d = attr_q | 8'h04;
              8'd52: attr_d = attr_q | 8'h08;
              8'd53: attr_d = attr_q | 8'h10;
              8'd55: attr_d = attr_q | 8'h20;
              8'd56: attr_d = attr_q | 8'h40;
              8'd57: attr_d = attr_q | 8'h80;
              default: ;
            endcase
          end
          PH_FG: begin
            fore_d      = ColW'({1'b0, last_q} - {1'b0, ByteZero});
            need_lookup = 1'b1;
          end
          PH_BG: begin
            back_d      = ColW'({1'b0, last_q} - {1'b0, ByteZero});
            need_lookup = 1'b1;
          end
          default: ;
        endcase
        if (in_byte_i == ByteEnd) begin
          phase_d = PH_PRINT;
        end else begin
          c       = ByteOpen;
          phase_d = PH_MOD;
        end
      end else if (last_q == 8'd50) begin
        phase_d = PH_UNDO;
      end else if (last_q == 8'd51) begin
        phase_d = PH_FG;
      end else if (last_q == 8'd52) begin
        phase_d = PH_BG;
      end
    end else begin
      if (in_byte_i == ByteEsc) begin
        phase_d = PH_MOD;
      end else if (in_byte_i != 8'd0) begin
        printed_d = 1'b1;
        cp_d      = in_byte_i[7] ? cp437_high(in_byte_i[6:0]) : {8'd0, in_byte_i};
      end
    end
    last_d = c;
  end

  // pair table search and append
  asgr_pair_chain u_chain (
    .clk_i    (clk_i),
    .shift_i  (shift),
    .search_i ({fore_q, back_q}),
    .count_i  (count_q),
    .lookup_o (lookup)
  );

  always_comb begin
    shift   = 1'b0;
    count_d = count_q;
    full_d  = 1'b0;
    pair_d  = pair_q;
    if (lookup.hit) begin
      pair_d = 9'({1'b0, base_q} + {2'b0, count_q} - {3'b0, lookup.pos});
    end else if (count_q >= CountW'(PairDepth)) begin
      full_d = 1'b1;
      pair_d = '0;
    end else begin
      shift   = (state_q == ST_SEARCH);
      count_d = count_q + 1'b1;
      pair_d  = 9'({1'b0, base_q} + {2'b0, count_q} + 9'd1);
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = need_lookup ? ST_SEARCH : ST_OUT;
      ST_SEARCH: state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o  = 1'b1;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // parser state and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_PRINT;
      last_q    <= '0;
      fore_q    <= '0;
      back_q    <= '0;
      attr_q    <= '0;
      pair_q    <= '0;
      count_q   <= '0;
      printed_q <= 1'b0;
      cp_q      <= '0;
      full_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        phase_q   <= phase_d;
        last_q    <= last_d;
        fore_q    <= fore_d;
        back_q    <= back_d;
        attr_q    <= attr_d;
        printed_q <= printed_d;
        cp_q      <= cp_d;
        full_q    <= 1'b0;
      end
      if (state_q == ST_SEARCH) begin
        pair_q  <= pair_d;
        count_q <= count_d;
        full_q  <= full_d;
      end
    end
  end

  assign printed_o    = printed_q;
  assign code_point_o = cp_q;
  assign attr_mask_o  = attr_q;
  assign pair_id_o    = pair_q;
  assign table_full_o = full_q;

`ifndef ASSERT_OFF
  a_full_zero_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> pair_id_o == 9'd0)
    else $error("table full with nonzero pair");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(PairDepth))
    else $error("pair count overflow");
  a_search_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |=> out_valid_o)
    else $error("search not followed by result");
  a_no_print_no_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !printed_o |-> code_point_o == 16'd0)
    else $error("code point on unprinted word");
`endif

endmodule

[tb/tb_ansi_sgr_attribute_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ansi_sgr_attribute_parser
// Drives text bytes and SGR sequences into the parser, predicts each result
// word in the testbench and compares every field in order of arrival.
// ----------------------------------------------------------------------------
module tb_ansi_sgr_attribute_parser;
  import asgr_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic        printed;
    logic [15:0] code_point;
    logic [7:0]  attr_mask;
    logic [8:0]  pair_id;
    logic        table_full;
  } sgr_word_t;

  // directed row: byte, whether the word is typed in, and that word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       fixed;
    sgr_word_t  word;
  } sgr_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        printed_o;
  logic [15:0] code_point_o;
  logic [7:0]  attr_mask_o;
  logic [8:0]  pair_id_o;
  logic        table_full_o;

  ansi_sgr_attribute_parser i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .printed_o    (printed_o),
    .code_point_o (code_point_o),
    .attr_mask_o  (attr_mask_o),
    .pair_id_o    (pair_id_o),
    .table_full_o (table_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [7:0]    base_q;
  phase_e        phase_q;
  logic [7:0]    prev_q;
  logic [8:0]    fg_q, bg_q;
  logic [7:0]    attr_q;
  logic [8:0]    pair_q;
  logic [KeyW-1:0] pairs_q [PairDepth];
  int unsigned   npairs_q;

  sgr_word_t   pending_q[$];
  int unsigned errors;
  int unsigned words_seen;
  int unsigned fulls_seen;
  int unsigned cycles;
  int unsigned send_idle, recv_idle;

  // Finds the current pair or appends it; flags a full table
  function automatic logic [8:0] pair_lookup(ref logic full);
    logic [KeyW-1:0] key;
    key = {fg_q, bg_q};
    for (int i = 0; i < npairs_q; i++)
      if (pairs_q[i] == key) return 9'(base_q + i + 1);
    if (npairs_q >= PairDepth) begin
      full = 1'b1;
      return 9'd0;
    end
    pairs_q[npairs_q] = key;
    npairs_q++;
    return 9'(base_q + npairs_q);
  endfunction

  function automatic logic [15:0] glyph(input logic [6:0] i);
    logic [15:0] t [128];
    t = '{
      16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
      16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
      16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
      16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
      16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
      16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
      16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
      16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
      16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
      16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
      16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
      16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
      16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
      16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
      16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
      16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };
    return t[i];
  endfunction

  function automatic sgr_word_t parse_byte(input logic [7:0] b);
    sgr_word_t w;
    logic full;
    logic [7:0] c;
    full = 1'b0;
    c = b;
    w = '0;
    if (phase_q inside {PH_MOD, PH_UNDO, PH_FG, PH_BG}) begin
      if (c == ByteEnd || c == ByteSplit) begin
        if (phase_q == PH_MOD) begin
          case (prev_q)
            8'd48: begin
              attr_q = '0;
              fg_q = '1;
              bg_q = '1;
              pair_q = pair_lookup(full);
            end
            8'd49: attr_q |= 8'h01;
            8'd50: attr_q |= 8'h02;
            8'd51: attr_q |= 8'h04;
            8'd52: attr_q |= 8'h08;
            8'd53: attr_q |= 8'h10;
            8'd55: attr_q |= 8'h20;
            8'd56: attr_q |= 8'h40;
            8'd57: attr_q |= 8'h80;
            default: ;
          endcase
        end else if (phase_q == PH_FG) begin
          fg_q = 9'({1'b0, prev_q} - 9'(ByteZero));
          pair_q = pair_lookup(full);
        end else if (phase_q == PH_BG) begin
          bg_q = 9'({1'b0, prev_q} - 9'(ByteZero));
          pair_q = pair_lookup(full);
        end
        if (c == ByteEnd) phase_q = PH_PRINT;
        else begin
          c = ByteOpen;
          phase_q = PH_MOD;
        end
      end else begin
        if (prev_q == 8'd50) phase_q = PH_UNDO;
        else if (prev_q == 8'd51) phase_q = PH_FG;
        else if (prev_q == 8'd52) phase_q = PH_BG;
      end
    end else begin
      if (c == ByteEsc) phase_q = PH_MOD;
      else if (c != 8'd0) begin
        w.printed = 1'b1;
        // own CP437 high-half table
        w.code_point = (c > 8'd127) ? glyph(c[6:0]) : {8'd0, c};
      end
    end
    prev_q = c;
    w.attr_mask  = attr_q;
    w.pair_id    = pair_q;
    w.table_full = full;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on word %0d: %s got %0h, wanted %0h", words_seen, what, got, want);
    errors++;
  endtask

  // Sends one byte and queues its expected word; a typed-in word overrides.
  // Valid is dropped only for an idle gap, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [7:0] b, input logic fixed, input sgr_word_t w);
    sgr_word_t p;
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    p = parse_byte(b);
    pending_q.insert(pending_q.size(), fixed ? w : p);
    in_byte_i  <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_and_set(input logic [7:0] base);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= base;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    base_q = base;
  endtask

  // One SGR sequence with random content, sometimes broken
  task automatic send_sequence();
    int unsigned n;
    logic [7:0] d;
    send_byte(ByteEsc, 1'b0, '0);
    send_byte(ByteOpen, 1'b0, '0);
    n = $urandom_range(3, 1);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: send_byte(8'($urandom_range(57, 48)), 1'b0, '0);
        1, 2: begin
          send_byte(($urandom_range(1)) ? 8'd51 : 8'd52, 1'b0, '0);
          d = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(57, 48));
          send_byte(d, 1'b0, '0);
        end
        default: begin
          send_byte(8'd50, 1'b0, '0);
          send_byte(8'($urandom_range(57, 48)), 1'b0, '0);
        end
      endcase
      if (k + 1 < n) send_byte(ByteSplit, 1'b0, '0);
    end
    if ($urandom_range(9) != 0) send_byte(ByteEnd, 1'b0, '0);
  endtask

  // receiver: stalls at random, compares fields against the oldest expectation
  initial begin
    sgr_word_t e;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= !(recv_idle != 0 && $urandom_range(99) < recv_idle);
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected word", code_point_o, 0);
        end else begin
          e = pending_q.pop_front();
          if (printed_o !== e.printed) report_mismatch("printed", printed_o, e.printed);
          if (code_point_o !== e.code_point)
            report_mismatch("code_point", code_point_o, e.code_point);
          if (attr_mask_o !== e.attr_mask) report_mismatch("attr_mask", attr_mask_o, e.attr_mask);
          if (pair_id_o !== e.pair_id)
            report_mismatch("pair_id", pair_id_o, e.pair_id);
          if (table_full_o !== e.table_full)
            report_mismatch("table_full", table_full_o, e.table_full);
          if (e.table_full) fulls_seen++;
        end
        words_seen++;
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  sgr_row_t rows [$];

  initial begin
    errors = 0;
    words_seen = 0;
    fulls_seen = 0;
    send_idle = 27;
    recv_idle = 59;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_byte_i = '0;
    base_q = PairBaseReset;
    phase_q = PH_PRINT;
    prev_q = '0;
    fg_q = '0;
    bg_q = '0;
    attr_q = '0;
    pair_q = '0;
    npairs_q = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: NUL, byte extremes, each kind of code, splitter, bad colour digit
    rows = '{
      '{8'd0,   1'b1, sgr_word_t'{1'b0, 16'h0000, 8'h00, 9'd0, 1'b0}},
      '{8'd1,   1'b1, sgr_word_t'{1'b1, 16'h0001, 8'h00, 9'd0, 1'b0}},
      '{8'd127, 1'b1, sgr_word_t'{1'b1, 16'h007F, 8'h00, 9'd0, 1'b0}},
      '{8'd128, 1'b1, sgr_word_t'{1'b1, 16'h00C7, 8'h00, 9'd0, 1'b0}},
      '{8'd254, 1'b1, sgr_word_t'{1'b1, 16'h25A0, 8'h00, 9'd0, 1'b0}},
      '{8'd255, 1'b0, '0},
      '{ByteEsc, 1'b0, '0}, '{ByteOpen, 1'b0, '0}, '{8'd49, 1'b0, '0},
      '{ByteSplit, 1'b0, '0}, '{8'd57, 1'b0, '0}, '{ByteSplit, 1'b0, '0},
      '{8'd51, 1'b0, '0}, '{8'd55, 1'b0, '0}, '{ByteSplit, 1'b0, '0},
      '{8'd52, 1'b0, '0}, '{8'd32, 1'b0, '0}, '{ByteSplit, 1'b0, '0},
      '{8'd50, 1'b0, '0}, '{8'd51, 1'b0, '0}, '{ByteSplit, 1'b0, '0},
      '{8'd48, 1'b0, '0}, '{ByteEnd, 1'b0, '0}, '{8'd0, 1'b0, '0}
    };
    foreach (rows[i]) send_byte(rows[i].in_byte, rows[i].fixed, rows[i].word);

    // random: three idling phases, base at both extremes and in between
    for (int ph = 0; ph < 3; ph++) begin
      drain_and_set(ph == 0 ? 8'd255 : (ph == 1 ? 8'd0 : 8'($urandom)));
      send_idle = (ph == 0) ? 27 : (ph == 1 ? 59 : 0);
      recv_idle = (ph == 0) ? 59 : (ph == 1 ? 27 : 0);
      while (words_seen < 24 + (ph + 1) * 460) begin
        if ($urandom_range(3) == 0) send_byte(8'($urandom), 1'b0, '0);
        else send_sequence();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("checked %0d result words over three base settings and idle mixes", words_seen);
    $display("colour pairs stored %0d, table-full words %0d", npairs_q, fulls_seen);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
